FILE: design/scq_pkg.sv
package scq_pkg;

    localparam int DEPTH_DEF     = 128;
    localparam int WORD_BITS_DEF = 32;

    localparam int VALUE_W  = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;
    localparam int SLOT_W   = 8;

    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam req_t REQ_ENQ    = 2'd0;
    localparam req_t REQ_DEQ    = 2'd1;
    localparam req_t REQ_SEARCH = 2'd2;

    localparam status_t STATUS_DONE  = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

endpackage

FILE: design/searchable_circular_queue.sv
// Searchable circular queue: a ring buffer of DEPTH signed words in one
// synchronous memory (one write port, one registered read port).
// Input channel: in_valid / in_stall carry req_type and value, one request
// per word: enqueue, dequeue, or search for a key.
// Output channel: out_valid / out_stall carry one result word per request:
// status, entry_count, front_value, rear_value and found_slot.
// Path from accept to result valid:
//   enqueue, rejected request, unknown code, search of empty queue: on accept
//   dequeue: one memory read fetches the new front entry first
//   search: k = entries compared (1 to entry_count), one memory read per
//   cycle walking from the front.
// One request is in flight at a time; the next one is taken once the result
// is loaded into the output register and that register is free or draining.
// When the receiver stalls, the result holds in the output register and
// in_stall rises until it is taken.
// Reset empties the queue (count zero, head at slot zero) and drops any
// pending result; memory contents are not cleared.
module searchable_circular_queue #(
    parameter int DEPTH     = scq_pkg::DEPTH_DEF,
    parameter int WORD_BITS = scq_pkg::WORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  scq_pkg::req_t                         req_type,
    input  logic signed [scq_pkg::VALUE_W-1:0]    value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output scq_pkg::status_t                      status,
    output logic        [scq_pkg::COUNT_W-1:0]    entry_count,
    output logic signed [scq_pkg::VALUE_W-1:0]    front_value,
    output logic signed [scq_pkg::VALUE_W-1:0]    rear_value,
    output logic signed [scq_pkg::SLOT_W-1:0]     found_slot
);
    import scq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DEQ    = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        next_slot = (s == SW'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    logic [WORD_BITS-1:0] store_mem [DEPTH];

    logic [1:0]  state_reg, state_next;
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic out_valid_reg, out_valid_next;

    logic signed [WORD_BITS-1:0] front_reg, front_next;
    logic signed [WORD_BITS-1:0] rear_reg, rear_next;
    logic signed [WORD_BITS-1:0] key_reg, key_next;
    logic [SW-1:0] cmp_slot_reg, cmp_slot_next;
    logic [CW-1:0] left_reg, left_next;
    logic signed [WORD_BITS-1:0] rd_data_reg;

    status_t                   status_reg, status_next;
    logic [COUNT_W-1:0]        count_out_reg, count_out_next;
    logic signed [VALUE_W-1:0] front_out_reg, front_out_next;
    logic signed [VALUE_W-1:0] rear_out_reg, rear_out_next;
    logic signed [SLOT_W-1:0]  slot_out_reg, slot_out_next;

    logic signed [WORD_BITS-1:0] key_in;
    logic          accept;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    logic [SW-1:0] rd_addr;
    logic          load_out;
    status_t       o_status;
    logic [CW-1:0] o_count;
    logic signed [WORD_BITS-1:0] o_front;
    logic signed [WORD_BITS-1:0] o_rear;
    logic signed [SLOT_W-1:0]    o_slot;
    logic signed [VALUE_W-1:0]   o_front32;
    logic signed [VALUE_W-1:0]   o_rear32;
    logic [SW-1:0] head_inc;
    logic [SW-1:0] tail_inc;

    assign key_in    = WORD_BITS'(value);
    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign head_inc  = next_slot(head_reg);
    assign tail_inc  = next_slot(tail_reg);
    assign o_front32 = VALUE_W'(o_front);
    assign o_rear32  = VALUE_W'(o_rear);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        front_next     = front_reg;
        rear_next      = rear_reg;
        key_next       = key_reg;
        cmp_slot_next  = cmp_slot_reg;
        left_next      = left_reg;
        wr_en          = 1'b0;
        wr_addr        = tail_inc;
        rd_addr        = head_reg;
        load_out       = 1'b0;
        o_status       = STATUS_DONE;
        o_count        = count_reg;
        o_front        = front_reg;
        o_rear         = rear_reg;
        o_slot         = '1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_ENQ:
                        begin
                            load_out = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                o_status = STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                tail_next  = tail_inc;
                                count_next = count_reg + 1'b1;
                                rear_next  = key_in;
                                if (count_reg == '0)
                                begin
                                    front_next = key_in;
                                end
                                o_count = count_next;
                                o_front = front_next;
                                o_rear  = key_in;
                            end
                        end
                        REQ_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                load_out = 1'b1;
                                o_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                head_next  = head_inc;
                                count_next = count_reg - 1'b1;
                                rd_addr    = head_inc;
                                state_next = ST_DEQ;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                load_out = 1'b1;
                            end
                            else
                            begin
                                rd_addr       = head_reg;
                                cmp_slot_next = head_reg;
                                left_next     = count_reg;
                                key_next      = key_in;
                                state_next    = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_DEQ:
            begin
                front_next = rd_data_reg;
                o_front    = rd_data_reg;
                load_out   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SEARCH:
            begin
                if (rd_data_reg == key_reg)
                begin
                    o_slot     = SLOT_W'(cmp_slot_reg);
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (left_reg == CW'(1))
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmp_slot_next = next_slot(cmp_slot_reg);
                    left_next     = left_reg - 1'b1;
                    rd_addr       = next_slot(cmp_slot_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        status_next    = status_reg;
        count_out_next = count_out_reg;
        front_out_next = front_out_reg;
        rear_out_next  = rear_out_reg;
        slot_out_next  = slot_out_reg;
        if (load_out)
        begin
            status_next    = o_status;
            count_out_next = COUNT_W'(o_count);
            front_out_next = (o_count == '0) ? '0 : o_front32;
            rear_out_next  = (o_count == '0) ? '0 : o_rear32;
            slot_out_next  = o_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= SW'(DEPTH - 1);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg     <= front_next;
        rear_reg      <= rear_next;
        key_reg       <= key_next;
        cmp_slot_reg  <= cmp_slot_next;
        left_reg      <= left_next;
        status_reg    <= status_next;
        count_out_reg <= count_out_next;
        front_out_reg <= front_out_next;
        rear_out_reg  <= rear_out_next;
        slot_out_reg  <= slot_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= key_in;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = count_out_reg;
    assign front_value = front_out_reg;
    assign rear_value  = rear_out_reg;
    assign found_slot  = slot_out_reg;

endmodule

FILE: design/scq_checker.sv
module scq_checker #(
    parameter int DEPTH = scq_pkg::DEPTH_DEF
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input scq_pkg::status_t                     status,
    input logic        [scq_pkg::COUNT_W-1:0]   entry_count,
    input logic signed [scq_pkg::VALUE_W-1:0]   front_value,
    input logic signed [scq_pkg::VALUE_W-1:0]   rear_value,
    input logic signed [scq_pkg::SLOT_W-1:0]    found_slot
);
    import scq_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_count)
            && $stable(front_value) && $stable(rear_value) && $stable(found_slot))
        else $error("stalled result word changed");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_count == '0 |-> front_value == '0 && rear_value == '0)
        else $error("empty queue reports nonzero front or rear");

    a_reject_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_DONE |-> found_slot == '1)
        else $error("rejected request reports a slot");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_FULL |-> entry_count == COUNT_W'(DEPTH))
        else $error("full rejection with count below depth");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_EMPTY |-> entry_count == '0)
        else $error("empty rejection with nonzero count");

endmodule

bind searchable_circular_queue scq_checker #(.DEPTH(DEPTH)) u_scq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_count (entry_count),
    .front_value (front_value),
    .rear_value  (rear_value),
    .found_slot  (found_slot)
);
